[design/psla_pkg.sv]
// ----------------------------------------------------------------------------
// psla_pkg
// shared types and operation codes of the packed simd lane alu
// ----------------------------------------------------------------------------
package psla_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned CMD_W  = 5;
  localparam int unsigned IMM_W  = 16;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [IMM_W-1:0]  imm_t;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD16 = 5'd0,
    OP_SUB16 = 5'd1,
    OP_SL16  = 5'd2,
    OP_SR16  = 5'd3,
    OP_LT16  = 5'd4,
    OP_LE16  = 5'd5,
    OP_EQ16  = 5'd6,
    OP_SEL16 = 5'd7,
    OP_ADD   = 5'd8,
    OP_SUB   = 5'd9,
    OP_MUL   = 5'd10,
    OP_SL    = 5'd11,
    OP_SR    = 5'd12,
    OP_LT    = 5'd13,
    OP_LE    = 5'd14,
    OP_EQ    = 5'd15,
    OP_SEL   = 5'd16,
    OP_AND   = 5'd17,
    OP_OR    = 5'd18,
    OP_XOR   = 5'd19,
    OP_MOV   = 5'd20,
    OP_XCHG  = 5'd21,
    OP_MOVIL = 5'd22,
    OP_MOVIH = 5'd23
  } op_t;

  typedef struct packed {
    op_t   cmd;
    word_t d;
    word_t b;
    word_t c;
    imm_t  imm;
  } operands_t;

endpackage

[design/packed_simd_lane_alu_core.sv]
// ----------------------------------------------------------------------------
// packed_simd_lane_alu_core
// integer datapath of one shader lane, paired 16-bit and 32-bit operations
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  in_     | in  | command, dest_value, src_b, src_c, immediate | -
//  out_    | out | result                                      | illegal
//
//  three register stages: operand capture, execute with partial products,
//  product sum and result select
//  one transfer per cycle in each direction while the output is not stalled
//  rst_n clears only the stage valid bits
//  a stage holds while its successor is full and stalled, empty stages
//  fill up, so no transfer is lost or repeated
// ----------------------------------------------------------------------------
module packed_simd_lane_alu_core
  import psla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command[4:0], dest_value[36:5], src_b[68:37], src_c[100:69],
  // immediate[116:101], zero fill up to bit 119
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result[31:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // illegal[0]
  output logic                  out_tuser
);

  logic      s1_v_r, s2_v_r, s3_v_r;
  logic      s1_rdy, s2_rdy, s3_rdy;
  operands_t s1_op_r;

  word_t     alu_nxt;
  logic      ill_nxt;
  word_t     s2_alu_r, s2_mul_lo_r;
  half_t     s2_mul_hi_r;
  logic      s2_ismul_r, s2_ill_r;

  word_t     s3_res_r;
  logic      s3_ill_r;

  assign s3_rdy    = !s3_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_tvalid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_op_r.cmd <= op_t'(in_tdata[4:0]);
      s1_op_r.d   <= in_tdata[36:5];
      s1_op_r.b   <= in_tdata[68:37];
      s1_op_r.c   <= in_tdata[100:69];
      s1_op_r.imm <= in_tdata[116:101];
    end
  end

  // execute
  always_comb begin
    half_t dl, dh, bl, bh, cl, ch;
    logic  big32;
    dl    = s1_op_r.d[HALF_W-1:0];
    dh    = s1_op_r.d[WORD_W-1:HALF_W];
    bl    = s1_op_r.b[HALF_W-1:0];
    bh    = s1_op_r.b[WORD_W-1:HALF_W];
    cl    = s1_op_r.c[HALF_W-1:0];
    ch    = s1_op_r.c[WORD_W-1:HALF_W];
    big32 = |s1_op_r.c[WORD_W-1:5];
    alu_nxt = '0;
    ill_nxt = 1'b0;
    case (s1_op_r.cmd)
      OP_ADD16: alu_nxt = {dh + bh, dl + bl};
      OP_SUB16: alu_nxt = {dh - bh, dl - bl};
      OP_SL16: begin
        alu_nxt[WORD_W-1:HALF_W] = (|bh[HALF_W-1:4]) ? '0 : dh << bh[3:0];
        alu_nxt[HALF_W-1:0]      = (|bl[HALF_W-1:4]) ? '0 : dl << bl[3:0];
      end
      OP_SR16: begin
        alu_nxt[WORD_W-1:HALF_W] = (|bh[HALF_W-1:4]) ? '0 : dh >> bh[3:0];
        alu_nxt[HALF_W-1:0]      = (|bl[HALF_W-1:4]) ? '0 : dl >> bl[3:0];
      end
      OP_LT16: begin
        alu_nxt[HALF_W] = $signed(dh) < $signed(bh);
        alu_nxt[0]      = $signed(dl) < $signed(bl);
      end
      OP_LE16: begin
        alu_nxt[HALF_W] = $signed(dh) <= $signed(bh);
        alu_nxt[0]      = $signed(dl) <= $signed(bl);
      end
      OP_EQ16: begin
        alu_nxt[HALF_W] = dh == bh;
        alu_nxt[0]      = dl == bl;
      end
      OP_SEL16: alu_nxt = {(|ch) ? dh : bh, (|cl) ? dl : bl};
      OP_ADD:   alu_nxt = s1_op_r.b + s1_op_r.c;
      OP_SUB:   alu_nxt = s1_op_r.b - s1_op_r.c;
      OP_MUL:   alu_nxt = '0;
      OP_SL:    alu_nxt = big32 ? '0 : s1_op_r.b << s1_op_r.c[4:0];
      OP_SR:    alu_nxt = big32 ? '0 : s1_op_r.b >> s1_op_r.c[4:0];
      OP_LT:    alu_nxt[0] = s1_op_r.b < s1_op_r.c;
      OP_LE:    alu_nxt[0] = s1_op_r.b <= s1_op_r.c;
      OP_EQ:    alu_nxt[0] = s1_op_r.b == s1_op_r.c;
      OP_SEL:   alu_nxt = (|s1_op_r.c) ? s1_op_r.d : s1_op_r.b;
      OP_AND:   alu_nxt = s1_op_r.d & s1_op_r.b;
      OP_OR:    alu_nxt = s1_op_r.d | s1_op_r.b;
      OP_XOR:   alu_nxt = s1_op_r.d ^ s1_op_r.b;
      OP_MOV:   alu_nxt = s1_op_r.b;
      OP_XCHG:  alu_nxt = {bl, bh};
      OP_MOVIL: alu_nxt = {bh, s1_op_r.imm};
      OP_MOVIH: alu_nxt = {s1_op_r.imm, bl};
      default:  ill_nxt = 1'b1;
    endcase
  end

  // partial products: full word by low half, low half by high half
  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_alu_r    <= alu_nxt;
      s2_mul_lo_r <= s1_op_r.b * {half_t'(0), s1_op_r.c[HALF_W-1:0]};
      s2_mul_hi_r <= s1_op_r.b[HALF_W-1:0] * s1_op_r.c[WORD_W-1:HALF_W];
      s2_ismul_r  <= s1_op_r.cmd == OP_MUL;
      s2_ill_r    <= ill_nxt;
    end
  end

  // product sum and result select
  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_res_r <= s2_ismul_r ? s2_mul_lo_r + {s2_mul_hi_r, half_t'(0)} : s2_alu_r;
      s3_ill_r <= s2_ill_r;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = s3_res_r;
  assign out_tuser  = s3_ill_r;

endmodule

[tb/sv/tb_packed_simd_lane_alu_core.sv]
// ----------------------------------------------------------------------------
// tb_packed_simd_lane_alu_core
// self-checking bench for the packed simd lane alu: directed corner operands
// for every operation, then random operand streams with random stalls on both
// stream sides, each result checked in order against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_packed_simd_lane_alu_core;
  import psla_pkg::*;

  typedef struct packed {
    word_t word;
    logic  bad;
  } lane_out_t;

  class lane_scoreboard;
    lane_out_t   pending_q[$];
    int unsigned mismatches;
    int unsigned operands_seen;
    int unsigned results_seen;
    int unsigned illegal_seen;

    function new();
      mismatches    = 0;
      operands_seen = 0;
      results_seen  = 0;
      illegal_seen  = 0;
    endfunction

    // new destination value for one operand set
    function lane_out_t lane_result(logic [CMD_W-1:0] code, word_t d, word_t b, word_t c,
                                    imm_t imm);
      lane_out_t o;
      half_t     dl, dh, bl, bh;
      dl = d[15:0];
      dh = d[31:16];
      bl = b[15:0];
      bh = b[31:16];
      o.word = '0;
      o.bad  = 1'b0;
      case (code)
        OP_ADD16: o.word = {half_t'(dh + bh), half_t'(dl + bl)};
        OP_SUB16: o.word = {half_t'(dh - bh), half_t'(dl - bl)};
        OP_SL16:  o.word = {(bh >= HALF_W) ? half_t'(0) : half_t'(dh << bh),
                            (bl >= HALF_W) ? half_t'(0) : half_t'(dl << bl)};
        OP_SR16:  o.word = {(bh >= HALF_W) ? half_t'(0) : half_t'(dh >> bh),
                            (bl >= HALF_W) ? half_t'(0) : half_t'(dl >> bl)};
        OP_LT16: begin
          o.word[16] = $signed(dh) < $signed(bh);
          o.word[0]  = $signed(dl) < $signed(bl);
        end
        OP_LE16: begin
          o.word[16] = $signed(dh) <= $signed(bh);
          o.word[0]  = $signed(dl) <= $signed(bl);
        end
        OP_EQ16: begin
          o.word[16] = dh == bh;
          o.word[0]  = dl == bl;
        end
        OP_SEL16: o.word = {(c[31:16] != 0) ? dh : bh, (c[15:0] != 0) ? dl : bl};
        OP_ADD:   o.word = b + c;
        OP_SUB:   o.word = b - c;
        OP_MUL:   o.word = word_t'(b * c);
        OP_SL:    o.word = (c >= WORD_W) ? word_t'(0) : (b << c);
        OP_SR:    o.word = (c >= WORD_W) ? word_t'(0) : (b >> c);
        OP_LT:    o.word = {31'd0, b < c};
        OP_LE:    o.word = {31'd0, b <= c};
        OP_EQ:    o.word = {31'd0, b == c};
        OP_SEL:   o.word = (c != 0) ? d : b;
        OP_AND:   o.word = d & b;
        OP_OR:    o.word = d | b;
        OP_XOR:   o.word = d ^ b;
        OP_MOV:   o.word = b;
        OP_XCHG:  o.word = {bl, bh};
        OP_MOVIL: o.word = {bh, imm};
        OP_MOVIH: o.word = {imm, bl};
        default:  o.bad  = 1'b1;
      endcase
      return o;
    endfunction

    function void note_operands(logic [CMD_W-1:0] code, word_t d, word_t b, word_t c,
                                imm_t imm);
      lane_out_t o;
      o = lane_result(code, d, b, c, imm);
      if (o.bad) illegal_seen++;
      operands_seen++;
      pending_q.push_back(o);
    endfunction

    function void check_result(word_t word, logic bad);
      lane_out_t o;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing pending: result %h illegal %b", word, bad);
        mismatches++;
      end else begin
        o = pending_q.pop_front();
        if (word !== o.word) begin
          $error("result mismatch: expected %h, actual %h", o.word, word);
          mismatches++;
        end
        if (bad !== o.bad) begin
          $error("illegal mismatch: expected %b, actual %b", o.bad, bad);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  lane_scoreboard sb = new();
  bit             send_steady = 1'b0;
  int unsigned    rx_cycle    = 0;

  packed_simd_lane_alu_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // operand transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_operands(in_tdata[4:0], in_tdata[36:5], in_tdata[68:37], in_tdata[100:69],
                       in_tdata[116:101]);
  end

  // result side: check, then stall at random with one quiet stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 1200 && rx_cycle < 1700)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(99) >= 29);
  end

  task automatic push_operands(logic [CMD_W-1:0] code, word_t d, word_t b, word_t c,
                               imm_t imm);
    while (!send_steady && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, imm, c, b, d, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0: w = 32'h0000_0000;
          1: w = 32'hffff_ffff;
          2: w = 32'h8000_0000;
          3: w = 32'h7fff_ffff;
          4: w = 32'h0000_ffff;
          default: w = 32'hffff_0000;
        endcase
      end
      1: w = $urandom_range(40);
      2: w = {16'($urandom_range(8)), 16'($urandom_range(8))} ^ ($urandom_range(1) ?
             32'h8000_8000 : 32'h0);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic random_operands();
    logic [CMD_W-1:0] code;
    word_t            d, b, c;
    imm_t             imm;
    if ($urandom_range(99) < 8) code = CMD_W'($urandom_range(31, 24));
    else code = CMD_W'($urandom_range(23, 0));
    d   = pick_word();
    b   = pick_word();
    c   = pick_word();
    imm = imm_t'($urandom);
    case (code)
      OP_SL16, OP_SR16:
        if ($urandom_range(1)) b = {16'($urandom_range(20)), 16'($urandom_range(20))};
      OP_SL, OP_SR:
        if ($urandom_range(1)) c = $urandom_range(40);
      OP_SEL16, OP_SEL:
        case ($urandom_range(3))
          0: c = '0;
          1: c = c & 32'hffff_0000;
          2: c = c & 32'h0000_ffff;
          default: ;
        endcase
      OP_LT16, OP_LE16, OP_EQ16:
        case ($urandom_range(3))
          0: b = d;
          1: b = {d[31:16], b[15:0]};
          2: b = {b[31:16], d[15:0]};
          default: ;
        endcase
      OP_LT, OP_LE, OP_EQ:
        case ($urandom_range(2))
          0: c = b;
          1: c = b + 1;
          default: ;
        endcase
      default: ;
    endcase
    push_operands(code, d, b, c, imm);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_operands(OP_ADD16, 32'hffff_7fff, 32'h0001_0001, 32'h0, 16'h0000);
    push_operands(OP_SUB16, 32'h0000_8000, 32'h0001_0001, 32'h0, 16'hffff);
    push_operands(OP_SL16,  32'hffff_ffff, 32'h0010_000f, 32'h0, 16'h0000);
    push_operands(OP_SL16,  32'h1234_8001, 32'hffff_0001, 32'h0, 16'h0000);
    push_operands(OP_SR16,  32'hffff_ffff, 32'h000f_0010, 32'h0, 16'h0000);
    push_operands(OP_LT16,  32'h8000_7fff, 32'h7fff_8000, 32'h0, 16'h0000);
    push_operands(OP_LE16,  32'h7fff_8000, 32'h7fff_8000, 32'h0, 16'h0000);
    push_operands(OP_EQ16,  32'hffff_0000, 32'hffff_0001, 32'h0, 16'h0000);
    push_operands(OP_SEL16, 32'haaaa_5555, 32'h1111_2222, 32'h0001_0000, 16'h0000);
    push_operands(OP_ADD,   32'h0, 32'hffff_ffff, 32'h0000_0001, 16'h0000);
    push_operands(OP_SUB,   32'h0, 32'h0000_0000, 32'h0000_0001, 16'h0000);
    push_operands(OP_MUL,   32'h0, 32'hffff_ffff, 32'hffff_ffff, 16'h0000);
    push_operands(OP_SL,    32'h0, 32'hffff_ffff, 32'h0000_001f, 16'h0000);
    push_operands(OP_SL,    32'h0, 32'hffff_ffff, 32'h0000_0020, 16'h0000);
    push_operands(OP_SR,    32'h0, 32'hffff_ffff, 32'hffff_ffff, 16'h0000);
    push_operands(OP_LT,    32'h0, 32'h7fff_ffff, 32'h8000_0000, 16'h0000);
    push_operands(OP_LE,    32'h0, 32'hffff_ffff, 32'hffff_ffff, 16'h0000);
    push_operands(OP_EQ,    32'h0, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    push_operands(OP_SEL,   32'hdead_beef, 32'h0bad_f00d, 32'h8000_0000, 16'h0000);
    push_operands(OP_AND,   32'hffff_ffff, 32'h8000_0001, 32'h0, 16'h0000);
    push_operands(OP_OR,    32'h0000_0000, 32'hffff_ffff, 32'h0, 16'h0000);
    push_operands(OP_XOR,   32'hffff_ffff, 32'h5555_aaaa, 32'h0, 16'h0000);
    push_operands(OP_MOV,   32'h0, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    push_operands(OP_XCHG,  32'h0, 32'h1234_abcd, 32'h0, 16'h0000);
    push_operands(OP_MOVIL, 32'h0, 32'hffff_ffff, 32'h0, 16'h0000);
    push_operands(OP_MOVIH, 32'h0, 32'h0000_0000, 32'h0, 16'hffff);
    push_operands(5'd24, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    push_operands(5'd31, 32'h1234_5678, 32'h9abc_def0, 32'h0, 16'h1234);

    for (int n = 0; n < 1550; n++) begin
      send_steady = (n >= 600 && n < 850);
      random_operands();
    end
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d operand transfers, %0d result transfers checked, %0d undefined codes",
             sb.operands_seen, sb.results_seen, sb.illegal_seen);
    $display("all paired and word operations driven, with random stalls on both sides");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[packed_simd_lane_alu_core.f]
design/psla_pkg.sv
design/packed_simd_lane_alu_core.sv
tb/sv/tb_packed_simd_lane_alu_core.sv
